[rtl/core/msp_pkg.sv]
// Shared codes and the move folding function for the maze path simplifier.
package msp_pkg;

	localparam logic [1:0] MV_LEFT    = 2'd0;
	localparam logic [1:0] MV_FORWARD = 2'd1;
	localparam logic [1:0] MV_RIGHT   = 2'd2;
	localparam logic [1:0] MV_BACK    = 2'd3;

	localparam logic OP_EXPLORE = 1'b0;
	localparam logic OP_REPLAY  = 1'b1;

	typedef logic [1:0] move_t;

	typedef struct packed {
		logic  hit;
		move_t move;
	} fold_t;

	// Result of folding prev, back, new into a single move.
	function automatic fold_t fold_move(input move_t prev, input move_t nxt);
		fold_t r;
		r.hit  = 1'b0;
		r.move = MV_LEFT;
		case ({prev, nxt})
			{MV_LEFT, MV_LEFT}: begin
				r.hit  = 1'b1;
				r.move = MV_FORWARD;
			end
			{MV_LEFT, MV_FORWARD}: begin
				r.hit  = 1'b1;
				r.move = MV_RIGHT;
			end
			{MV_LEFT, MV_RIGHT}: begin
				r.hit  = 1'b1;
				r.move = MV_BACK;
			end
			{MV_FORWARD, MV_LEFT}: begin
				r.hit  = 1'b1;
				r.move = MV_RIGHT;
			end
			{MV_FORWARD, MV_FORWARD}: begin
				r.hit  = 1'b1;
				r.move = MV_BACK;
			end
			{MV_RIGHT, MV_LEFT}: begin
				r.hit  = 1'b1;
				r.move = MV_BACK;
			end
			default: begin
				r.hit  = 1'b0;
				r.move = MV_LEFT;
			end
		endcase
		return r;
	endfunction

endpackage

[rtl/core/maze_path_simplifier_unit.sv]
// Left-hand maze follower that shortens its stored path on line and replays it.
// Each item takes two steps: one to read the path memory, one to fold, write and
// update the pointers, which waits until the output register is free or taken; the
// next word is taken in the cycle after that.
// A finished result waits in the output register while the next word is read in.
// Reset clears pointers, count and handshake state; the path memory is not cleared.
module maze_path_simplifier_unit
	import msp_pkg::*;
#(
	parameter int PATH_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // left_open, forward_open, right_open, back_open, zero fill
	input  logic [0:0]  s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // move[1:0], move_valid, path_count[8:0], overflow, zero fill
);

	localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
	localparam int CW = $clog2(PATH_DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(PATH_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(PATH_DEPTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	move_t path_mem [PATH_DEPTH];

	logic          state_q;
	logic [AW-1:0] newest_q;
	logic [AW-1:0] oldest_q;
	logic [CW-1:0] count_q;

	logic          op_s1;
	logic [3:0]    open_s1;
	move_t         rd_a_s1;
	move_t         rd_b_s1;

	logic          out_valid_q;
	logic [15:0]   out_data_q;

	logic          in_fire;
	logic          done;
	logic [AW-1:0] top_idx;
	logic [AW-1:0] below_idx;
	logic [AW-1:0] newest_inc;
	logic [AW-1:0] oldest_inc;
	logic [AW-1:0] rd_a_addr;

	logic          pick_ok;
	move_t         pick;
	fold_t         fold;
	logic          we;
	logic [AW-1:0] waddr;
	move_t         wdata;
	logic [AW-1:0] newest_d;
	logic [AW-1:0] oldest_d;
	logic [CW-1:0] count_d;
	move_t         res_move;
	logic          res_valid;
	logic          res_ovf;
	logic [CW+8:0] count_ext;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign done     = (state_q == ST_EXEC) && (!out_valid_q || m_tready);

	assign top_idx    = (newest_q == '0) ? LAST_IDX : newest_q - AW'(1);
	assign below_idx  = (top_idx == '0) ? LAST_IDX : top_idx - AW'(1);
	assign newest_inc = (newest_q == LAST_IDX) ? '0 : newest_q + AW'(1);
	assign oldest_inc = (oldest_q == LAST_IDX) ? '0 : oldest_q + AW'(1);
	assign rd_a_addr  = (s_tuser[0] == OP_REPLAY) ? oldest_q : top_idx;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_a_s1 <= path_mem[rd_a_addr];
			rd_b_s1 <= path_mem[below_idx];
			op_s1   <= s_tuser[0];
			open_s1 <= s_tdata[3:0];
		end
		if (we) begin
			path_mem[waddr] <= wdata;
		end
	end

	always_comb begin
		pick_ok = |open_s1;
		if (open_s1[0]) begin
			pick = MV_LEFT;
		end else if (open_s1[1]) begin
			pick = MV_FORWARD;
		end else if (open_s1[2]) begin
			pick = MV_RIGHT;
		end else begin
			pick = MV_BACK;
		end
		fold = fold_move(rd_b_s1, pick);
		if (!(count_q >= CW'(2) && rd_a_s1 == MV_BACK)) begin
			fold.hit = 1'b0;
		end

		we        = 1'b0;
		waddr     = newest_q;
		wdata     = pick;
		newest_d  = newest_q;
		oldest_d  = oldest_q;
		count_d   = count_q;
		res_move  = MV_LEFT;
		res_valid = 1'b0;
		res_ovf   = 1'b0;

		if (op_s1 == OP_REPLAY) begin
			if (count_q != '0) begin
				res_move  = rd_a_s1;
				res_valid = 1'b1;
				oldest_d  = oldest_inc;
				count_d   = count_q - CW'(1);
			end
		end else if (pick_ok) begin
			res_move  = pick;
			res_valid = 1'b1;
			if (fold.hit) begin
				we       = done;
				waddr    = below_idx;
				wdata    = fold.move;
				newest_d = top_idx;
				count_d  = count_q - CW'(1);
			end else if (count_q >= FULL_CNT) begin
				res_ovf = 1'b1;
			end else begin
				we       = done;
				newest_d = newest_inc;
				count_d  = count_q + CW'(1);
			end
		end
		count_ext = (CW + 9)'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			newest_q    <= '0;
			oldest_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (done) begin
				newest_q    <= newest_d;
				oldest_q    <= oldest_d;
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_data_q <= {3'b000, res_ovf, count_ext[8:0], res_valid, res_move};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("stored move count exceeds the path depth");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && out_valid_q && !m_tready) |=> (state_q == ST_EXEC))
		else $error("item completed while the output word was still pending");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[12]) |-> (count_q == FULL_CNT))
		else $error("overflow reported while the store is not full");

	a_write_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_EXEC))
		else $error("path memory written outside the execute cycle");

endmodule
